/* hw/rtl/hrga_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrga_pkg: shared types and constants of the heart rate gated average.
// Holds the ring geometry, the divider widths and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hrga_pkg;

    localparam int RING_DEPTH   = 5;
    localparam int TICKS_PER_US = 40;

    localparam int PERIOD_W = 32;
    localparam int RATE_W   = 16;
    localparam int BPM_W    = 8;
    localparam int FRAC_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = $clog2(RING_DEPTH * 255 + 1);

    // Shared restoring divider: quotient/dividend shifter, remainder, divisor.
    localparam int DIV_W  = PERIOD_W;
    localparam int REM_W  = DIV_W + 1;
    localparam int STEP_W = $clog2(DIV_W);

    // Ticks to whole microseconds by a rounded-up reciprocal. With the shift
    // at the period width plus the bits of the tick rate, the truncated
    // product equals the truncated quotient for every 32-bit period.
    localparam int RECIP_SH = PERIOD_W + $clog2(TICKS_PER_US);
    localparam int RECIP_W  = PERIOD_W + 2;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US));
    localparam int PROD_W   = PERIOD_W + RECIP_W;

    // Sixty million microseconds per minute, scaled to UQ8.8.
    localparam logic [63:0] RATE_NUM = 64'd60000000 << FRAC_W;
    // Quotient overflows 16 bits exactly when micro <= RATE_NUM >> 16.
    localparam logic [REM_W-1:0]  NUM_HI = REM_W'(RATE_NUM >> RATE_W);
    localparam logic [RATE_W-1:0] NUM_LO = RATE_W'(RATE_NUM);

    localparam logic [RATE_W-1:0] RATE_SAT = '1;

    localparam int OUT_W   = RATE_W + 1 + BPM_W + 1;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'd1;

    typedef struct packed {
        logic load_in;    // latch the period in ticks
        logic scale;      // ticks to whole microseconds
        logic step;       // one restoring division step
        logic set_sat;    // rate saturates
        logic load_rate;  // start numerator / micro division
        logic take_rate;  // latch the quotient as the rate
        logic store;      // gate the rate and write the ring
        logic scan;       // add one ring slot into the sum
        logic load_avg;   // start sum / count division
        logic load_out;   // fill the output word register
    } t_cmd;

    typedef struct packed {
        logic sat;        // micro too small for a 16-bit quotient
        logic scan_last;  // scan pointer on the last slot
        logic cnt_zero;   // ring holds no rate
    } t_status;

    typedef struct packed {
        logic              avg_valid;
        logic [BPM_W-1:0]  avg_rate;
        logic              accepted;
        logic [RATE_W-1:0] inst_rate;
    } t_result;

endpackage

/* hw/rtl/hrga_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrga_ctrl: sequencing controller of the heart rate gated average.
// Walks one word through the microsecond scale, the two divisions, the ring
// update and the scan, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module hrga_ctrl import hrga_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIV_T = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_DIV_R = 10'b00_0000_1000,
        S_RATE  = 10'b00_0001_0000,
        S_STORE = 10'b00_0010_0000,
        S_SCAN  = 10'b00_0100_0000,
        S_AVG   = 10'b00_1000_0000,
        S_DIV_A = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DIV_T;
                end
            end
            S_DIV_T: begin
                o_cmd.scale = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.sat) begin
                    o_cmd.set_sat = 1'b1;
                    n_state       = S_STORE;
                end else begin
                    o_cmd.load_rate = 1'b1;
                    n_step          = STEP_W'(RATE_W - 1);
                    n_state         = S_DIV_R;
                end
            end
            S_DIV_R: begin
                o_cmd.step = 1'b1;
                n_step     = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                o_cmd.take_rate = 1'b1;
                n_state         = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                if (i_status.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.load_avg = 1'b1;
                    n_step         = STEP_W'(SUM_W - 1);
                    n_state        = S_DIV_A;
                end
            end
            S_DIV_A: begin
                o_cmd.step = 1'b1;
                n_step     = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/hrga_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrga_dpath: datapath of the heart rate gated average.
// A shared restoring divider, the rate gate, the five-slot ring with its
// scan accumulator, the bound registers and the output word register.
// ----------------------------------------------------------------------------
module hrga_dpath import hrga_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BPM_W-1:0]     i_cfg_data,
    input  logic [PERIOD_W-1:0]  i_period_ticks,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output t_result              o_result
);

    // Divider registers.
    logic [REM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_div;
    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_div_ext;
    logic              w_ge;

    // Reciprocal scale of the period to whole microseconds.
    logic [PROD_W-1:0] w_prod;
    logic [DIV_W-1:0]  w_micro;

    // Rate, gate and scan registers.
    logic [RATE_W-1:0] r_rate;
    logic              r_acc;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_scan;

    // Ring and configuration.
    logic [RATE_W-1:0] r_ring [RING_DEPTH];
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [RATE_W-1:0] r_last;
    logic [BPM_W-1:0]  r_min;
    logic [BPM_W-1:0]  r_max;
    logic              w_accept;
    logic [RATE_W-1:0] w_slot_val;

    t_result           r_res;
    logic [BPM_W-1:0]  w_avg;

    assign w_rem_sh  = {r_rem[REM_W-2:0], r_quo[DIV_W-1]};
    assign w_div_ext = {1'b0, r_div};
    assign w_ge      = (w_rem_sh >= w_div_ext);

    assign w_prod  = PROD_W'(r_quo) * PROD_W'(RECIP_M);
    assign w_micro = DIV_W'(w_prod >> RECIP_SH);

    // The last written slot always holds the value just before the write
    // pointer, and an untouched ring reads zero there, as r_last does.
    assign w_accept = (r_rate > {r_min, {FRAC_W{1'b0}}}) &&
                      (r_rate < {r_max, {FRAC_W{1'b0}}}) &&
                      (r_rate != r_last);

    assign n_wslot    = (r_wslot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
    assign w_slot_val = r_ring[r_scan];
    assign w_avg      = (r_cnt == '0) ? '0 : r_quo[BPM_W-1:0];

    assign o_status.sat       = ({1'b0, r_quo} <= NUM_HI);
    assign o_status.scan_last = (r_scan == SLOT_W'(RING_DEPTH - 1));
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_result           = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_quo <= i_period_ticks;
        end else if (i_cmd.scale) begin
            r_quo <= w_micro;
        end else if (i_cmd.load_rate) begin
            r_rem <= NUM_HI;
            r_quo <= DIV_W'(NUM_LO) << (DIV_W - RATE_W);
            r_div <= r_quo;
        end else if (i_cmd.load_avg) begin
            r_rem <= '0;
            r_quo <= DIV_W'(r_sum) << (DIV_W - SUM_W);
            r_div <= DIV_W'(r_cnt);
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? (w_rem_sh - w_div_ext) : w_rem_sh;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end

        if (i_cmd.set_sat) begin
            r_rate <= RATE_SAT;
        end else if (i_cmd.take_rate) begin
            r_rate <= r_quo[RATE_W-1:0];
        end

        if (i_cmd.store) begin
            r_acc  <= w_accept;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_scan <= '0;
        end else if (i_cmd.scan) begin
            if (w_slot_val != '0) begin
                r_sum <= r_sum + SUM_W'(w_slot_val[RATE_W-1:FRAC_W]);
                r_cnt <= r_cnt + 1'b1;
            end
            r_scan <= r_scan + 1'b1;
        end

        if (i_cmd.load_out) begin
            r_res.inst_rate <= r_rate;
            r_res.accepted  <= r_acc;
            r_res.avg_rate  <= w_avg;
            r_res.avg_valid <= (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_wslot <= '0;
            r_last  <= '0;
            r_min   <= BPM_W'(40);
            r_max   <= BPM_W'(150);
        end else begin
            if (i_cmd.store && w_accept) begin
                r_ring[r_wslot] <= r_rate;
                r_last          <= r_rate;
                r_wslot         <= n_wslot;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MIN_RATE: r_min <= i_cfg_data;
                    CFG_MAX_RATE: r_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/heart_rate_gated_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_gated_average: pulse period to heart rate with a gated average.
// Converts a period in timer ticks to beats per minute in UQ8.8, keeps the
// plausible, changed rates in a small ring and reports their average.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word
// s_axis    in         tdata[31:0] period_ticks
// m_axis    out        tdata[15:0] inst_rate, [16] accepted, [24:17] avg_rate,
//                      [25] avg_valid, [31:26] zero
// cfg       in         index 0 min_rate, index 1 max_rate, 8-bit data
//
// From acceptance a word passes a reciprocal scale to microseconds, 16
// divider steps for the rate (skipped when the rate saturates), the ring
// store, a five-slot scan and 11 divider steps for the average (skipped
// when the ring is empty). The next word is taken the cycle after the
// result loads; a stalled output holds the controller only in its last state.
// Reset is synchronous, active low, empties the ring and restores 40 and 150.
//
module heart_rate_gated_average import hrga_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream: [31:0] period_ticks.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [TDATA_W-1:0]   i_s_axis_tdata,
    // Output stream: [15:0] inst_rate, [16] accepted, [24:17] avg_rate,
    // [25] avg_valid, upper bits zero.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [TDATA_W-1:0]   o_m_axis_tdata,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BPM_W-1:0]     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;

    // The controller sequences each word and owns both handshakes; the
    // datapath only reacts to its commands.
    hrga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hrga_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_period_ticks (i_s_axis_tdata[PERIOD_W-1:0]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result       (w_result)
    );

    // Packed result; the struct already lists fields from the top bit down.
    assign o_m_axis_tdata = TDATA_W'(w_result);

`ifndef SYNTHESIS
    // The controller never issues two datapath commands in one cycle.
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command active");

    // An accepted word starts a computation, so the input closes next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still ready after accepting a word");

    // A stored rate is never the empty mark nor saturated, and it leaves the ring non-empty.
    a_accept_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_result.accepted) |->
            (w_result.avg_valid && w_result.inst_rate != '0 &&
             w_result.inst_rate != RATE_SAT))
        else $error("accepted rate inconsistent with ring state");

    // An empty ring reports a zero average.
    a_empty_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !w_result.avg_valid) |-> (w_result.avg_rate == '0))
        else $error("nonzero average from an empty ring");
`endif

endmodule

/* verif/hrga_rate_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrga_rate_checker: scoreboard for the heart rate gated average.
// Follows the bound registers and every accepted period word, predicts the
// rate, the ring update and the average, and compares each output word with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hrga_rate_checker import hrga_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // [31:0] period_ticks.
    input  logic [TDATA_W-1:0]   i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // [15:0] inst_rate, [16] accepted, [24:17] avg_rate, [25] avg_valid.
    input  logic [TDATA_W-1:0]   i_m_tdata,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BPM_W-1:0]     i_cfg_data,
    output int                   o_error_count,
    output int                   o_pending
);

    localparam logic [BPM_W-1:0] LOW_BOUND_RESET  = 8'd40;
    localparam logic [BPM_W-1:0] HIGH_BOUND_RESET = 8'd150;
    // One minute in microseconds, scaled by 256 for the UQ8.8 quotient.
    localparam logic [63:0] MINUTE_UQ88 = 64'd60000000 << FRAC_W;

    logic [RATE_W-1:0] stored_rates [RING_DEPTH];
    int unsigned       next_slot;
    logic [BPM_W-1:0]  low_bound;
    logic [BPM_W-1:0]  high_bound;
    t_result           expected_words [$];

    function automatic logic [RATE_W-1:0] bpm_of_period(input logic [PERIOD_W-1:0] period);
        logic [63:0] micros;
        logic [63:0] quot;
        micros = 64'(period) / TICKS_PER_US;
        if (micros == 0)
            return RATE_SAT;
        quot = MINUTE_UQ88 / micros;
        return (quot > 64'(RATE_SAT)) ? RATE_SAT : RATE_W'(quot);
    endfunction

    // Gates the new rate into the ring, then averages the occupied slots.
    task automatic apply_period(input logic [PERIOD_W-1:0] period, output t_result word);
        logic [RATE_W-1:0] rate;
        int unsigned       prev_slot;
        int unsigned       bpm_sum;
        int unsigned       occupied;
        logic              took;
        rate      = bpm_of_period(period);
        prev_slot = (next_slot == 0) ? RING_DEPTH - 1 : next_slot - 1;
        took      = (rate > {low_bound, 8'h00}) && (rate < {high_bound, 8'h00}) &&
                    (rate != stored_rates[prev_slot]);
        if (took) begin
            stored_rates[next_slot] = rate;
            next_slot = (next_slot + 1 == RING_DEPTH) ? 0 : next_slot + 1;
        end
        bpm_sum  = 0;
        occupied = 0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            if (stored_rates[k] != '0) begin
                bpm_sum += stored_rates[k][RATE_W-1:FRAC_W];
                occupied++;
            end
        end
        word.inst_rate = rate;
        word.accepted  = took;
        word.avg_rate  = (occupied != 0) ? BPM_W'(bpm_sum / occupied) : '0;
        word.avg_valid = (occupied != 0);
    endtask

    always @(posedge i_clk) begin : track
        t_result want;
        t_result got;
        t_result pred;
        if (!i_rst_n) begin
            foreach (stored_rates[k])
                stored_rates[k] = '0;
            next_slot  = 0;
            low_bound  = LOW_BOUND_RESET;
            high_bound = HIGH_BOUND_RESET;
            expected_words.delete();
            o_error_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MIN_RATE: low_bound  = i_cfg_data;
                    CFG_MAX_RATE: high_bound = i_cfg_data;
                    default: ;
                endcase
            end
            // The output side is checked before this edge's input is predicted.
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[OUT_W-1:0]);
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h", i_m_tdata);
                    o_error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.inst_rate !== want.inst_rate) begin
                        $error("inst_rate: expected %h, actual %h", want.inst_rate, got.inst_rate);
                        o_error_count++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %b, actual %b", want.accepted, got.accepted);
                        o_error_count++;
                    end
                    if (got.avg_rate !== want.avg_rate) begin
                        $error("avg_rate: expected %0d, actual %0d", want.avg_rate, got.avg_rate);
                        o_error_count++;
                    end
                    if (got.avg_valid !== want.avg_valid) begin
                        $error("avg_valid: expected %b, actual %b", want.avg_valid, got.avg_valid);
                        o_error_count++;
                    end
                    if (i_m_tdata[TDATA_W-1:OUT_W] !== '0) begin
                        $error("padding: expected %h, actual %h", {(TDATA_W - OUT_W){1'b0}},
                               i_m_tdata[TDATA_W-1:OUT_W]);
                        o_error_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_period(i_s_tdata[PERIOD_W-1:0], pred);
                expected_words.push_back(pred);
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

/* verif/heart_rate_gated_average_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_gated_average_test: testbench top of the heart rate converter.
// Feeds pulse periods through the input stream under several bound settings
// and flow-control mixes; a separate checker predicts and compares every
// output word, and this module reports the verdict.
// ----------------------------------------------------------------------------
module heart_rate_gated_average_test;
    import hrga_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_RATE;
    logic [BPM_W-1:0]     cfg_data = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [TDATA_W-1:0]   m_tdata;

    int error_count;
    int pending_words;

    // Percent chance per cycle that the sender holds back a word, and that
    // the receiver drops its ready.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    // Recently sent periods, replayed to hit the repeat check and near-equal rates.
    logic [PERIOD_W-1:0] recent_periods [4] = '{default: 32'd40_000_000};
    logic [PERIOD_W-1:0] last_period = 32'd40_000_000;

    // Directed words, sent under the reset bounds of 40 and 150 bpm. They
    // cover periods under one microsecond, the exact saturation edge, the
    // longest period, a full ring that wraps, a repeat of the last stored
    // rate across the wrap, and rates sitting exactly on either bound.
    logic [PERIOD_W-1:0] directed_periods [$] = '{
        32'd0,            // no whole microsecond: saturates
        32'd39,           // still below one microsecond
        32'd40,           // one microsecond: far above 16 bits, saturates
        32'd9_375_000,    // first period of the last microsecond count that overflows
        32'd9_375_040,    // first period that fits, 0xFFFF, above the bound
        32'hFFFF_FFFF,    // longest period, well below the lower bound
        32'd40_000_000,   // 60 bpm, first stored rate
        32'd40_000_000,   // same rate again: rejected as a repeat
        32'd20_000_000,   // 120 bpm
        32'd24_000_000,   // 100 bpm
        32'd30_000_000,   // 80 bpm
        32'd26_666_680,   // about 90 bpm, fills the ring, pointer wraps
        32'd26_666_680,   // repeat of the last slot while the pointer is 0
        32'd16_000_000,   // exactly 150 bpm: not strictly below the bound
        32'd60_000_000,   // exactly 40 bpm: not strictly above the bound
        32'd59_960_000,   // just above 40 bpm, overwrites the oldest slot
        32'd16_000_040,   // just below 150 bpm
        32'd40_000_000,   // 60 bpm again, now different from its neighbor
        32'h8000_0000     // top bit alone
    };

    heart_rate_gated_average i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    hrga_rate_checker u_rate_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending_words)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // The receiver redraws its ready every cycle from the current stall rate.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one word and returns at the edge that accepts it. The valid is
    // only lowered when a gap is drawn, so back-to-back words keep it high.
    task automatic send_period(input logic [PERIOD_W-1:0] period);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(period);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Waits until every predicted word has come out. The checker's count
    // is registered, so the task waits for an edge before it looks.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words != 0);
    endtask

    // Writes both bounds on consecutive edges while the block is idle.
    task automatic write_bounds(input logic [BPM_W-1:0] low, input logic [BPM_W-1:0] high);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_RATE;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_MAX_RATE;
        cfg_data  <= high;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Most words are plausible pulse periods spanning roughly 12 to 256 bpm;
    // the rest replay recent periods, nudge them by a few ticks, land in the
    // saturating range, or are plain 32-bit noise.
    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return $urandom_range(200_000_000, 9_000_000);
        else if (pick < 65)
            return last_period;
        else if (pick < 72)
            return recent_periods[$urandom_range(3)];
        else if (pick < 80)
            return last_period + $urandom_range(80);
        else if (pick < 88)
            return $urandom_range(9_400_000, 0);
        else
            return $urandom();
    endfunction

    task automatic run_phase(input int gap_pct, input int stall_pct,
                             input logic [BPM_W-1:0] low, input logic [BPM_W-1:0] high,
                             input int words);
        logic [PERIOD_W-1:0] period;
        wait_drained();
        write_bounds(low, high);
        send_gap_pct = gap_pct;
        recv_stall_pct <= stall_pct;
        repeat (words) begin
            period = pick_period();
            send_period(period);
            last_period = period;
            recent_periods[$urandom_range(3)] = period;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [BPM_W-1:0] low;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_periods[k])
            send_period(directed_periods[k]);
        s_tvalid <= 1'b0;

        // Widest window, a narrow window, crossed and equal bounds, the reset
        // values again, then a random window.
        run_phase(0,  0,  8'd0,   8'd255, 400);
        run_phase(84, 0,  8'd60,  8'd120, 400);
        run_phase(0,  84, 8'd255, 8'd0,   250);
        run_phase(36, 36, 8'd100, 8'd100, 200);
        run_phase(84, 0,  8'd40,  8'd150, 350);
        low = BPM_W'($urandom_range(90, 20));
        run_phase(36, 36, low, BPM_W'(low + $urandom_range(120, 10)), 350);

        // Let everything drain, then leave room for any stray output word.
        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Safety net: several times the slowest expected run.
    initial begin : watchdog
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
